// File: rtl/reb_pkg.sv
// Shared types and constants for the rotary encoder block.
package reb_pkg;

	localparam int COUNT_BITS     = 18;
	localparam int POS_BITS       = 16;
	localparam int REG_BITS       = 16;
	localparam int TIME_BITS      = 32;
	localparam int CFG_INDEX_BITS = 3;

	// Accepted pin pair: A in the upper bit, B in the lower bit.
	localparam logic [1:0] PIN_A_BIT = 2'b10;
	localparam logic [1:0] PIN_B_BIT = 2'b01;
	localparam logic [1:0] PAIR_00   = 2'b00;
	localparam logic [1:0] PAIR_01   = PIN_B_BIT;
	localparam logic [1:0] PAIR_10   = PIN_A_BIT;
	localparam logic [1:0] PAIR_11   = PIN_A_BIT | PIN_B_BIT;

	typedef enum logic {
		CMD_POLL = 1'b0,
		CMD_LOAD = 1'b1
	} cmd_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_SPEED_MODE     = 3'd0,
		CFG_MIN_VALUE      = 3'd1,
		CFG_MAX_VALUE      = 3'd2,
		CFG_DEBOUNCE_MS    = 3'd3,
		CFG_SHORT_PRESS_MS = 3'd4,
		CFG_LONG_PRESS_MS  = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic [1:0]          speed_mode;
		logic [REG_BITS-1:0] min_value;
		logic [REG_BITS-1:0] max_value;
		logic [REG_BITS-1:0] debounce_ms;
		logic [REG_BITS-1:0] short_press_ms;
		logic [REG_BITS-1:0] long_press_ms;
	} cfg_t;

	typedef struct packed {
		logic                 command;
		logic                 pin_a_level;
		logic                 pin_b_level;
		logic                 switch_level;
		logic [TIME_BITS-1:0] time_ms;
		logic [POS_BITS-1:0]  load_value;
	} in_item_t;

	typedef struct packed {
		logic [POS_BITS-1:0] position;
		logic                value_changed;
		logic                short_press;
		logic                long_press;
	} out_item_t;

endpackage

// File: rtl/reb_if.sv
// Valid/ready channel interfaces for encoder polls and encoder results.
interface reb_in_if;
	import reb_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 command;
	logic                 pin_a_level;
	logic                 pin_b_level;
	logic                 switch_level;
	logic [TIME_BITS-1:0] time_ms;
	logic [POS_BITS-1:0]  load_value;

	modport source (output valid, command, pin_a_level, pin_b_level, switch_level, time_ms,
		load_value, input ready);
	modport sink (input valid, command, pin_a_level, pin_b_level, switch_level, time_ms,
		load_value, output ready);
endinterface

interface reb_out_if;
	import reb_pkg::*;
	logic                valid;
	logic                ready;
	logic [POS_BITS-1:0] position;
	logic                value_changed;
	logic                short_press;
	logic                long_press;

	modport source (output valid, position, value_changed, short_press, long_press,
		input ready);
	modport sink (input valid, position, value_changed, short_press, long_press,
		output ready);
endinterface

// File: rtl/rotary_encoder_with_button.sv
// Rotary encoder with debounce and push button: an input register and a result register.
// Throughput one transaction per cycle while the receiver is ready; the step logic sits between the input
// register and the result register and updates the encoder state in that same cycle.
// A waiting result does not stop the input side: the input register takes one more item.
// Reset clears all encoder state and loads the register defaults (debounce 5,
// short press 50, long press 1000, others zero).
module rotary_encoder_with_button #(
	parameter int STAMP_BITS      = 32,
	parameter int STEP_COUNT_BITS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [reb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [reb_pkg::REG_BITS-1:0]       cfg_wdata,
	reb_in_if.sink                             in_ch,
	reb_out_if.source                          out_ch
);
	import reb_pkg::*;

	cfg_t      cfg_q;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result;
	out_item_t out_q;
	logic      out_valid_q;
	logic      advance;

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_mode     <= 2'd0;
			cfg_q.min_value      <= '0;
			cfg_q.max_value      <= '0;
			cfg_q.debounce_ms    <= REG_BITS'(5);
			cfg_q.short_press_ms <= REG_BITS'(50);
			cfg_q.long_press_ms  <= REG_BITS'(1000);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SPEED_MODE:     cfg_q.speed_mode     <= cfg_wdata[1:0];
				CFG_MIN_VALUE:      cfg_q.min_value      <= cfg_wdata;
				CFG_MAX_VALUE:      cfg_q.max_value      <= cfg_wdata;
				CFG_DEBOUNCE_MS:    cfg_q.debounce_ms    <= cfg_wdata;
				CFG_SHORT_PRESS_MS: cfg_q.short_press_ms <= cfg_wdata;
				CFG_LONG_PRESS_MS:  cfg_q.long_press_ms  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.command      <= in_ch.command;
			item_s1.pin_a_level  <= in_ch.pin_a_level;
			item_s1.pin_b_level  <= in_ch.pin_b_level;
			item_s1.switch_level <= in_ch.switch_level;
			item_s1.time_ms      <= in_ch.time_ms;
			item_s1.load_value   <= in_ch.load_value;
		end
	end

	reb_core #(
		.STAMP_BITS      (STAMP_BITS),
		.STEP_COUNT_BITS (STEP_COUNT_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) out_q <= result;
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.position      = out_q.position;
	assign out_ch.value_changed = out_q.value_changed;
	assign out_ch.short_press   = out_q.short_press;
	assign out_ch.long_press    = out_q.long_press;

endmodule

// File: rtl/reb_core.sv
// Encoder state and single-pass step logic: debounce, quadrature decode, button timing.
module reb_core #(
	parameter int STAMP_BITS      = 32,
	parameter int STEP_COUNT_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  reb_pkg::in_item_t  item,
	input  reb_pkg::cfg_t      cfg,
	output reb_pkg::out_item_t result
);
	import reb_pkg::*;

	logic                       acc_a_q, acc_a_d;
	logic                       acc_b_q, acc_b_d;
	logic [STAMP_BITS-1:0]      stamp_a_q, stamp_a_d;
	logic [STAMP_BITS-1:0]      stamp_b_q, stamp_b_d;
	logic [1:0]                 prev_pair_q, prev_pair_d;
	logic [COUNT_BITS-1:0]      count_q, count_d;
	logic [COUNT_BITS-1:0]      prev_count_q, prev_count_d;
	logic [STEP_COUNT_BITS-1:0] up_q, up_d;
	logic [STEP_COUNT_BITS-1:0] down_q, down_d;
	logic                       held_q, held_d;
	logic [STAMP_BITS-1:0]      press_q, press_d;

	logic [1:0]            shift;
	logic [1:0]            divmask;
	logic [1:0]            phase;
	logic [STAMP_BITS-1:0] now;
	logic [STAMP_BITS-1:0] diff_a;
	logic [STAMP_BITS-1:0] diff_b;
	logic [STAMP_BITS-1:0] held_time;
	logic [STAMP_BITS-1:0] debounce_ext;
	logic [COUNT_BITS-1:0] load_ext;
	logic [COUNT_BITS-1:0] lo;
	logic [COUNT_BITS-1:0] hi;
	logic [COUNT_BITS-1:0] pos_full;
	logic [1:0]            pair;
	logic                  step_up;
	logic                  step_down;
	logic                  net;

	// Mode three behaves as mode two; tolerance equals the shift.
	always_comb begin
		unique case (cfg.speed_mode)
			2'd0: begin
				shift   = 2'd0;
				divmask = 2'b00;
			end
			2'd1: begin
				shift   = 2'd1;
				divmask = 2'b01;
			end
			default: begin
				shift   = 2'd2;
				divmask = 2'b11;
			end
		endcase
	end

	assign now          = STAMP_BITS'(item.time_ms);
	assign diff_a       = now - stamp_a_q;
	assign diff_b       = now - stamp_b_q;
	assign held_time    = now - press_q;
	assign debounce_ext = STAMP_BITS'(cfg.debounce_ms);
	assign load_ext     = {2'b00, item.load_value};
	assign lo           = {2'b00, cfg.min_value} << shift;
	assign hi           = ({2'b00, cfg.max_value} << shift) + {16'd0, shift};

	always_comb begin
		acc_a_d      = acc_a_q;
		acc_b_d      = acc_b_q;
		stamp_a_d    = stamp_a_q;
		stamp_b_d    = stamp_b_q;
		prev_pair_d  = prev_pair_q;
		count_d      = count_q;
		prev_count_d = prev_count_q;
		up_d         = up_q;
		down_d       = down_q;
		held_d       = held_q;
		press_d      = press_q;
		pair         = prev_pair_q;
		step_up      = 1'b0;
		step_down    = 1'b0;
		net          = 1'b0;
		phase        = 2'b00;
		result       = '0;

		if (item.command == CMD_LOAD) begin
			count_d = load_ext << shift;
		end else begin
			// Take a pin edge only once the debounce window has passed.
			if (item.pin_a_level != acc_a_q && diff_a > debounce_ext) begin
				acc_a_d   = item.pin_a_level;
				stamp_a_d = now;
			end
			if (item.pin_b_level != acc_b_q && diff_b > debounce_ext) begin
				acc_b_d   = item.pin_b_level;
				stamp_b_d = now;
			end
			pair = (acc_a_d ? PIN_A_BIT : 2'b00) | (acc_b_d ? PIN_B_BIT : 2'b00);

			if (pair != prev_pair_q) begin
				step_up = (prev_pair_q == PAIR_00 && pair == PAIR_01) ||
					(prev_pair_q == PAIR_01 && pair == PAIR_11) ||
					(prev_pair_q == PAIR_11 && pair == PAIR_10) ||
					(prev_pair_q == PAIR_10 && pair == PAIR_00);
				step_down = (prev_pair_q == PAIR_00 && pair == PAIR_10) ||
					(prev_pair_q == PAIR_10 && pair == PAIR_11) ||
					(prev_pair_q == PAIR_11 && pair == PAIR_01) ||
					(prev_pair_q == PAIR_01 && pair == PAIR_00);
				if (step_up) begin
					if (up_q != '1) up_d = up_q + 1'b1;
					if (count_q < hi) count_d = count_q + 1'b1;
					net = up_d > down_q;
				end else if (step_down) begin
					if (down_q != '1) down_d = down_q + 1'b1;
					if (count_q > lo) count_d = count_q - 1'b1;
					net = down_d > up_q;
				end
				// At a detent boundary flag net motion and restart the tally.
				phase = count_d[1:0] + shift;
				if ((step_up || step_down) && (phase & divmask) == 2'b00) begin
					result.value_changed = (count_d != prev_count_q) && net;
					up_d   = '0;
					down_d = '0;
				end
				prev_pair_d  = pair;
				prev_count_d = count_d;
			end

			if (!item.switch_level) begin
				if (!held_q) press_d = now;
				held_d = 1'b1;
			end else if (held_q) begin
				held_d = 1'b0;
				if (held_time >= STAMP_BITS'(cfg.long_press_ms)) begin
					result.long_press = 1'b1;
				end else if (held_time >= STAMP_BITS'(cfg.short_press_ms)) begin
					result.short_press = 1'b1;
				end
			end
		end

		pos_full = count_d >> shift;
		result.position = (pos_full[COUNT_BITS-1:POS_BITS] != '0) ? '1 : pos_full[POS_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_a_q      <= 1'b0;
			acc_b_q      <= 1'b0;
			stamp_a_q    <= '0;
			stamp_b_q    <= '0;
			prev_pair_q  <= PAIR_00;
			count_q      <= '0;
			prev_count_q <= '0;
			up_q         <= '0;
			down_q       <= '0;
			held_q       <= 1'b0;
			press_q      <= '0;
		end else if (advance) begin
			acc_a_q      <= acc_a_d;
			acc_b_q      <= acc_b_d;
			stamp_a_q    <= stamp_a_d;
			stamp_b_q    <= stamp_b_d;
			prev_pair_q  <= prev_pair_d;
			count_q      <= count_d;
			prev_count_q <= prev_count_d;
			up_q         <= up_d;
			down_q       <= down_d;
			held_q       <= held_d;
			press_q      <= press_d;
		end
	end

endmodule

// File: tb/reb_checker.sv
// Checker for the rotary encoder block: predicts each result from the accepted polls and compares.
module reb_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [reb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [reb_pkg::REG_BITS-1:0]       cfg_wdata,
	reb_in_if                                  in_ch,
	reb_out_if                                 out_ch,
	output int                                 mismatches,
	output int                                 pending
);
	import reb_pkg::*;

	// register copies
	logic [1:0]            speed_r;
	logic [REG_BITS-1:0]   min_r, max_r, debounce_r, short_r, long_r;

	// encoder and button state
	logic                  acc_a, acc_b;
	logic [TIME_BITS-1:0]  stamp_a, stamp_b, press_t;
	logic [1:0]            last_pair;
	logic [COUNT_BITS-1:0] cnt, last_cnt;
	logic [7:0]            ups, downs;
	logic                  held;

	out_item_t             reports_due[$];

	// Close a detent when the count sits on a divider boundary; flag net motion.
	function automatic logic detent_flag(input logic upward, input logic [1:0] shift);
		logic [COUNT_BITS-1:0] divmask;
		logic                  flag;
		divmask = (COUNT_BITS'(1) << shift) - COUNT_BITS'(1);
		flag = 1'b0;
		if (((cnt + COUNT_BITS'(shift)) & divmask) == '0) begin
			if (cnt != last_cnt && (upward ? (ups > downs) : (downs > ups)))
				flag = 1'b1;
			ups = '0;
			downs = '0;
		end
		return flag;
	endfunction

	task automatic predict_report(input in_item_t it, output out_item_t res);
		logic [1:0]            shift;
		logic [1:0]            pair;
		logic [COUNT_BITS-1:0] lo, hi, scaled;
		logic [TIME_BITS-1:0]  span;
		logic                  moved_up, moved_down;
		shift = (speed_r == 2'd0) ? 2'd0 : ((speed_r == 2'd1) ? 2'd1 : 2'd2);
		res = '0;
		if (it.command == CMD_LOAD) begin
			cnt = COUNT_BITS'(it.load_value) << shift;
		end else begin
			if (it.pin_a_level != acc_a && (it.time_ms - stamp_a) > TIME_BITS'(debounce_r)) begin
				acc_a = it.pin_a_level;
				stamp_a = it.time_ms;
			end
			if (it.pin_b_level != acc_b && (it.time_ms - stamp_b) > TIME_BITS'(debounce_r)) begin
				acc_b = it.pin_b_level;
				stamp_b = it.time_ms;
			end
			pair = {acc_a, acc_b};
			if (pair != last_pair) begin
				lo = COUNT_BITS'(min_r) << shift;
				hi = (COUNT_BITS'(max_r) << shift) + COUNT_BITS'(shift);
				moved_up = (last_pair == PAIR_00 && pair == PAIR_01) ||
					(last_pair == PAIR_01 && pair == PAIR_11) ||
					(last_pair == PAIR_11 && pair == PAIR_10) ||
					(last_pair == PAIR_10 && pair == PAIR_00);
				moved_down = (last_pair == PAIR_00 && pair == PAIR_10) ||
					(last_pair == PAIR_10 && pair == PAIR_11) ||
					(last_pair == PAIR_11 && pair == PAIR_01) ||
					(last_pair == PAIR_01 && pair == PAIR_00);
				if (moved_up) begin
					if (ups != '1) ups++;
					if (cnt < hi) cnt++;
					res.value_changed = detent_flag(1'b1, shift);
				end else if (moved_down) begin
					if (downs != '1) downs++;
					if (cnt > lo) cnt--;
					res.value_changed = detent_flag(1'b0, shift);
				end
				// an invalid jump still moves the reference pair
				last_pair = pair;
				last_cnt = cnt;
			end
			if (!it.switch_level) begin
				if (!held) press_t = it.time_ms;
				held = 1'b1;
			end else if (held) begin
				span = it.time_ms - press_t;
				held = 1'b0;
				if (span >= TIME_BITS'(long_r)) res.long_press = 1'b1;
				else if (span >= TIME_BITS'(short_r)) res.short_press = 1'b1;
			end
		end
		scaled = cnt >> shift;
		res.position = (scaled > COUNT_BITS'(16'hFFFF)) ? 16'hFFFF : scaled[POS_BITS-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		in_item_t  poll_item;
		out_item_t want, got;
		if (!arst_n) begin
			speed_r = '0;
			min_r = '0;
			max_r = '0;
			debounce_r = 16'd5;
			short_r = 16'd50;
			long_r = 16'd1000;
			acc_a = 1'b0;
			acc_b = 1'b0;
			stamp_a = '0;
			stamp_b = '0;
			press_t = '0;
			last_pair = PAIR_00;
			cnt = '0;
			last_cnt = '0;
			ups = '0;
			downs = '0;
			held = 1'b0;
			reports_due.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SPEED_MODE:     speed_r = cfg_wdata[1:0];
					CFG_MIN_VALUE:      min_r = cfg_wdata;
					CFG_MAX_VALUE:      max_r = cfg_wdata;
					CFG_DEBOUNCE_MS:    debounce_r = cfg_wdata;
					CFG_SHORT_PRESS_MS: short_r = cfg_wdata;
					CFG_LONG_PRESS_MS:  long_r = cfg_wdata;
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				got = '{position: out_ch.position, value_changed: out_ch.value_changed,
					short_press: out_ch.short_press, long_press: out_ch.long_press};
				if (reports_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: pos %0d chg %0b short %0b long %0b",
							got.position, got.value_changed, got.short_press, got.long_press);
				end else begin
					want = reports_due.pop_front();
					if (got.position != want.position || got.value_changed != want.value_changed ||
						got.short_press != want.short_press || got.long_press != want.long_press) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("mismatch: expected pos %0d chg %0b short %0b long %0b, ",
								want.position, want.value_changed, want.short_press,
								want.long_press);
							$display("got pos %0d chg %0b short %0b long %0b",
								got.position, got.value_changed, got.short_press,
								got.long_press);
						end
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				poll_item = '{command: in_ch.command, pin_a_level: in_ch.pin_a_level,
					pin_b_level: in_ch.pin_b_level, switch_level: in_ch.switch_level,
					time_ms: in_ch.time_ms, load_value: in_ch.load_value};
				predict_report(poll_item, want);
				reports_due.push_back(want);
			end
			pending = reports_due.size();
		end
	end

endmodule

// File: tb/tb_top.sv
// Top of the rotary encoder testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb_top;
	import reb_pkg::*;

	localparam int IDLE_LIMIT = 3000;

	typedef struct {
		logic [1:0]          mode;
		logic [REG_BITS-1:0] min_v, max_v, debounce, short_ms, long_ms;
		int                  items;
		int                  flip_pct;
		bit                  rewind;
		logic [31:0]         t0;
		bit                  go_up;
	} phase_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	cfg_index_t          cfg_index = CFG_SPEED_MODE;
	logic [REG_BITS-1:0] cfg_wdata = '0;
	int                  mismatches, pending;
	int                  idle_cycles = 0;

	bit                  calm = 1'b0;
	bit                  stall_request = 1'b0;
	int                  stall_left = 0;

	logic [TIME_BITS-1:0] now_ms = '0;
	int                   enc_idx = 0;
	bit                   go_up = 1'b1;
	logic                 sw_level = 1'b1;
	logic [1:0]           quad_code [4] = '{PAIR_00, PAIR_01, PAIR_11, PAIR_10};

	phase_t plan [6] = '{
		'{2'd0, 16'd0,     16'd20,    16'd5,     16'd50,    16'd1000,  400, 5,  1'b0, 32'd0, 1'b1},
		'{2'd1, 16'd3,     16'd30,    16'd2,     16'd20,    16'd200,   400, 5,  1'b0, 32'd0, 1'b1},
		'{2'd2, 16'd0,     16'd8,     16'd0,     16'd0,     16'd100,   350, 0,  1'b0, 32'd0, 1'b0},
		'{2'd3, 16'd10,    16'd12,    16'd10,    16'd30,    16'd300,   300, 5,  1'b1,
			32'hFFFF_F000, 1'b1},
		'{2'd2, 16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  100, 10, 1'b0, 32'd0, 1'b0},
		'{2'd0, 16'd0,     16'hFFFF,  16'd0,     16'd0,     16'd0,     250, 3,  1'b0, 32'd0, 1'b1}
	};

	reb_in_if  feed();
	reb_out_if report();

	rotary_encoder_with_button i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (feed),
		.out_ch    (report)
	);

	reb_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_ch      (feed),
		.out_ch     (report),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver: random stalls, a calm stretch and one long hold-off on request.
	initial begin
		report.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				report.ready <= 1'b0;
			end else if (stall_request) begin
				stall_request = 1'b0;
				stall_left = 79;
				report.ready <= 1'b0;
			end else begin
				report.ready <= calm || ($urandom_range(99) >= 15);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((feed.valid && feed.ready) || (report.valid && report.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Entered and left at a falling edge; valid stays high into the next transaction.
	task automatic send_item(input in_item_t it);
		if (!calm && $urandom_range(99) < 7) begin
			feed.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		feed.valid <= 1'b1;
		feed.command <= it.command;
		feed.pin_a_level <= it.pin_a_level;
		feed.pin_b_level <= it.pin_b_level;
		feed.switch_level <= it.switch_level;
		feed.time_ms <= it.time_ms;
		feed.load_value <= it.load_value;
		do @(posedge clk); while (!feed.ready);
		@(negedge clk);
	endtask

	task automatic poll(input logic a, input logic b, input logic sw, input logic [31:0] t);
		in_item_t it;
		it.command = CMD_POLL;
		it.pin_a_level = a;
		it.pin_b_level = b;
		it.switch_level = sw;
		it.time_ms = t;
		it.load_value = POS_BITS'($urandom());
		send_item(it);
	endtask

	task automatic load(input logic [POS_BITS-1:0] v);
		in_item_t it;
		it.command = CMD_LOAD;
		it.pin_a_level = 1'($urandom_range(1));
		it.pin_b_level = 1'($urandom_range(1));
		it.switch_level = 1'($urandom_range(1));
		it.time_ms = $urandom();
		it.load_value = v;
		send_item(it);
	endtask

	// Drain all results, then write every register while the block is idle.
	task automatic program_registers(input phase_t p);
		feed.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SPEED_MODE;
		cfg_wdata <= REG_BITS'(p.mode);
		@(negedge clk);
		cfg_index <= CFG_MIN_VALUE;
		cfg_wdata <= p.min_v;
		@(negedge clk);
		cfg_index <= CFG_MAX_VALUE;
		cfg_wdata <= p.max_v;
		@(negedge clk);
		cfg_index <= CFG_DEBOUNCE_MS;
		cfg_wdata <= p.debounce;
		@(negedge clk);
		cfg_index <= CFG_SHORT_PRESS_MS;
		cfg_wdata <= p.short_ms;
		@(negedge clk);
		cfg_index <= CFG_LONG_PRESS_MS;
		cfg_wdata <= p.long_ms;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		phase_t               warmup;
		int                   roll;
		logic [TIME_BITS-1:0] dt;
		logic [1:0]           pins;
		logic [POS_BITS-1:0]  target;
		feed.valid = 1'b0;
		feed.command = CMD_POLL;
		feed.pin_a_level = 1'b0;
		feed.pin_b_level = 1'b0;
		feed.switch_level = 1'b1;
		feed.time_ms = '0;
		feed.load_value = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		warmup = '{2'd0, 16'd0, 16'd10, 16'd5, 16'd50, 16'd1000, 0, 0, 1'b0, 32'd0, 1'b1};
		program_registers(warmup);
		// full turn up, bounce rejected at exactly the debounce time, then down
		poll(1'b0, 1'b0, 1'b1, 32'd0);
		poll(1'b0, 1'b1, 1'b1, 32'd10);
		poll(1'b1, 1'b1, 1'b1, 32'd20);
		poll(1'b1, 1'b0, 1'b1, 32'd30);
		poll(1'b0, 1'b0, 1'b1, 32'd40);
		poll(1'b1, 1'b0, 1'b1, 32'd45);
		poll(1'b1, 1'b0, 1'b1, 32'd46);
		poll(1'b1, 1'b1, 1'b1, 32'd60);
		// both pins at once
		poll(1'b0, 1'b0, 1'b1, 32'd80);
		// hold below short, exactly short, exactly long
		poll(1'b0, 1'b0, 1'b0, 32'd100);
		poll(1'b0, 1'b0, 1'b1, 32'd149);
		poll(1'b0, 1'b0, 1'b0, 32'd200);
		poll(1'b0, 1'b0, 1'b1, 32'd250);
		poll(1'b0, 1'b0, 1'b0, 32'd300);
		poll(1'b0, 1'b0, 1'b1, 32'd1300);
		// count above the upper limit: up holds, down moves
		load(16'hFFFF);
		poll(1'b0, 1'b1, 1'b1, 32'd1310);
		poll(1'b0, 1'b0, 1'b1, 32'd1320);
		// at the lower limit
		load(16'h0000);
		poll(1'b1, 1'b0, 1'b1, 32'd1330);
		// press across the timestamp wrap
		poll(1'b1, 1'b1, 1'b0, 32'hFFFF_FFF0);
		poll(1'b0, 1'b1, 1'b1, 32'h0000_0040);
		enc_idx = 3;
		now_ms = 32'h0000_0100;

		foreach (plan[k]) begin
			program_registers(plan[k]);
			if (plan[k].rewind) now_ms = plan[k].t0;
			go_up = plan[k].go_up;
			for (int n = 0; n < plan[k].items; n++) begin
				calm = (k == 1 && n < 250);
				if (k == 0 && n == 100) stall_request = 1'b1;
				roll = $urandom_range(99);
				if (roll < 5) begin
					roll = $urandom_range(3);
					target = (roll < 2) ? POS_BITS'($urandom()) :
						((roll == 2) ? plan[k].min_v : 16'hFFFF);
					load(target);
				end else begin
					roll = $urandom_range(99);
					if (roll < 60)
						dt = TIME_BITS'(plan[k].debounce) + 1 + $urandom_range(20);
					else if (roll < 85)
						dt = $urandom_range(TIME_BITS'(plan[k].debounce));
					else
						dt = $urandom_range(2000);
					now_ms = now_ms + dt;
					if ($urandom_range(99) < 3) now_ms = $urandom();
					if ($urandom_range(99) < plan[k].flip_pct) go_up = !go_up;
					roll = $urandom_range(99);
					if (roll < 75)
						enc_idx = go_up ? (enc_idx + 1) % 4 : (enc_idx + 3) % 4;
					else if (roll >= 85)
						enc_idx = $urandom_range(3);
					if ($urandom_range(99) < 8) sw_level = !sw_level;
					pins = quad_code[enc_idx];
					poll(pins[1], pins[0], sw_level, now_ms);
				end
			end
			// leave a large count behind for the next setting
			load(16'hFFFF);
		end
		calm = 1'b0;
		feed.valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
